/* sv/tsmh_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the text search match highlighter
// no dependencies
package tsmh_pkg;

  localparam int MaxQueryDef   = 16;
  localparam int MaxMatchesDef = 256;

  localparam int QLEN_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 16;
  localparam int COL_W    = 12;
  localparam int TOTAL_W  = 9;
  localparam int CIDX_W   = 8;
  localparam int LEVEL_W  = 2;
  localparam int KIND_W   = 3;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN = 3'd0,
    KIND_TEXT  = 3'd1,
    KIND_NEXT  = 3'd2,
    KIND_PREV  = 3'd3,
    KIND_PROBE = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LOW  = 2'd0,
    REG_QUERY_HIGH = 2'd1,
    REG_QUERY_LEN  = 2'd2,
    REG_CASE_SENS  = 2'd3
  } cfg_reg_e;

  localparam logic [LEVEL_W-1:0] LEVEL_NONE    = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MATCH   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_CURRENT = 2'd2;

  // control shared by every window cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } cell_ctrl_t;

  // fold A-Z to lower case when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) r = b + CASE_OFFSET;
    return r;
  endfunction

endpackage

/* sv/tsmh_cell.sv */
`timescale 1ns / 1ps
// one cell of the text window: holds a byte, passes it on, compares to a query byte
// depends on tsmh_pkg
module tsmh_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsmh_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          query_i,
  input  logic                use_i,
  output logic [7:0]          byte_o,
  output logic                ok_o
);
  import tsmh_pkg::*;

  logic [7:0] byte_q, byte_d;

  // next byte of this cell
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) byte_d = '0;
    else if (ctrl_i.shift) byte_d = byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) byte_q <= '0;
    else byte_q <= byte_d;
  end

  // compare the byte this cell will hold
  assign ok_o   = !use_i || (fold_byte(byte_d, ctrl_i.fold) == fold_byte(query_i, ctrl_i.fold));
  assign byte_o = byte_q;

endmodule

/* sv/tsmh_table.sv */
`timescale 1ns / 1ps
// match table memory: one write port, one registered read port
// depends on tsmh_pkg
module tsmh_table #(
  parameter int Depth = tsmh_pkg::MaxMatchesDef,
  parameter int IdxW  = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [IdxW-1:0]            waddr_i,
  input  logic [tsmh_pkg::ROW_W-1:0] wrow_i,
  input  logic [tsmh_pkg::COL_W-1:0] wcol_i,
  input  logic [IdxW-1:0]            raddr_i,
  output logic [tsmh_pkg::ROW_W-1:0] rrow_o,
  output logic [tsmh_pkg::COL_W-1:0] rcol_o
);
  import tsmh_pkg::*;

  logic [ROW_W+COL_W-1:0] mem [Depth];
  logic [ROW_W+COL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= {wrow_i, wcol_i};
    rdata_q <= mem[raddr_i];
  end

  assign rrow_o = rdata_q[ROW_W+COL_W-1:COL_W];
  assign rcol_o = rdata_q[COL_W-1:0];

endmodule

/* sv/text_search_match_highlighter.sv */
`timescale 1ns / 1ps
// text search match highlighter: window cell chain, match table, sequencer
// sequencing: an accepted item passes ST_CUR_RD, then ST_DONE, which loads the
// result register once it is free or m_axis_tready is high; a probe on an active
// search with matches first reads and checks table entries until a hit or the last
// one; one item at a time, s_axis_tready is high only in ST_IDLE
// reset: async active low clears window, counters, search state, config registers
module text_search_match_highlighter #(
  parameter int MAX_QUERY   = tsmh_pkg::MaxQueryDef,
  parameter int MAX_MATCHES = tsmh_pkg::MaxMatchesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tsmh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // text_byte, row, col
  input  logic [tsmh_pkg::KIND_W-1:0]         s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, match_found, found_row, found_col, match_total, current_index,
  // current_row, current_col, highlight_level
  output logic [tsmh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tsmh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsmh_pkg::CFG_W-1:0]          cfg_data_i
);
  import tsmh_pkg::*;

  localparam int IDX_W = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int CNT_W = $clog2(MAX_MATCHES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MATCHES);
  localparam logic [QLEN_W-1:0] QMAX = QLEN_W'(MAX_QUERY);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN_RD  = 5'b00010,
    ST_SCAN_CHK = 5'b00100,
    ST_CUR_RD   = 5'b01000,
    ST_DONE     = 5'b10000
  } state_e;

  // configuration registers
  logic [CFG_W-1:0]  qlow_q, qhigh_q;
  logic [QLEN_W-1:0] qlen_q;
  logic              csens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q <= '0; qhigh_q <= '0; qlen_q <= '0; csens_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUERY_LOW:  qlow_q  <= cfg_data_i;
        REG_QUERY_HIGH: qhigh_q <= cfg_data_i;
        REG_QUERY_LEN:  qlen_q  <= cfg_data_i[QLEN_W-1:0];
        REG_CASE_SENS:  csens_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [QLEN_W-1:0] eff_len;
  logic [127:0]      query_all;
  assign eff_len   = (qlen_q > QMAX) ? QMAX : qlen_q;
  assign query_all = {qhigh_q, qlow_q};

  // search state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic              active_q, active_d;
  logic [QLEN_W-1:0] latched_q, latched_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              found_q, found_d;
  logic [COL_W-1:0]  fcol_q, fcol_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // input fields
  logic              in_acc;
  kind_e             kind;
  logic [BYTE_W-1:0] in_byte;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign kind    = kind_e'(s_axis_tuser);
  assign in_byte = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[23:8];
  assign in_col  = s_axis_tdata[35:24];

  // window cell chain
  cell_ctrl_t        cctrl;
  logic [7:0]        chain [MAX_QUERY+1];
  logic [MAX_QUERY-1:0] cell_ok;
  logic              text_go;

  assign text_go     = in_acc && kind == KIND_TEXT && active_q && cnt_q < CNT_MAX;
  assign cctrl.shift = text_go;
  assign cctrl.clear = in_acc && kind == KIND_BEGIN && eff_len != '0;
  assign cctrl.fold  = !csens_q;
  assign chain[0]    = in_byte;

  for (genvar j = 0; j < MAX_QUERY; j++) begin : g_cell
    logic [QLEN_W-1:0] qidx;
    logic [7:0]        qb;
    assign qidx = eff_len - QLEN_W'(j + 1);
    assign qb   = query_all[{qidx[3:0], 3'b000} +: 8];
    tsmh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cctrl),
      .byte_i  (chain[j]),
      .query_i (qb),
      .use_i   (QLEN_W'(j) < eff_len),
      .byte_o  (chain[j+1]),
      .ok_o    (cell_ok[j])
    );
  end

  // match decision for a text byte
  logic             hit_text;
  logic [COL_W:0]   col_plus;
  assign col_plus = {1'b0, in_col} + 1'b1;
  assign hit_text = text_go && eff_len != '0 && col_plus >= (COL_W+1)'(eff_len) && &cell_ok;

  // match table
  logic [IDX_W-1:0] raddr;
  logic [ROW_W-1:0] rd_row;
  logic [COL_W-1:0] rd_col;
  assign raddr = (state_q == ST_SCAN_RD) ? scan_q : cur_q;

  tsmh_table #(.Depth(MAX_MATCHES), .IdxW(IDX_W)) u_table (
    .clk_i   (clk_i),
    .we_i    (hit_text),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wrow_i  (in_row),
    .wcol_i  (col_plus[COL_W-1:0] - COL_W'(eff_len)),
    .raddr_i (raddr),
    .rrow_o  (rd_row),
    .rcol_o  (rd_col)
  );

  // probe hit on the entry just read
  logic             probe_hit;
  logic [COL_W:0]   col_end;
  logic [CNT_W-1:0] scan_next;
  assign col_end   = {1'b0, rd_col} + (COL_W+1)'(latched_q);
  assign probe_hit = rd_row == row_q && col_q >= rd_col && {1'b0, col_q} < col_end;
  assign scan_next = CNT_W'(scan_q) + 1'b1;

  // sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; cur_d = cur_q; active_d = active_q;
    latched_d = latched_q; scan_d = scan_q; row_d = row_q; col_d = col_q;
    found_d = found_q; fcol_d = fcol_q; level_d = level_q;
    out_valid_d = out_valid_q && !m_axis_tready; out_data_d = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          row_d = in_row; col_d = in_col; found_d = 1'b0; fcol_d = '0;
          level_d = LEVEL_NONE; scan_d = '0; state_d = ST_CUR_RD;
          case (kind)
            KIND_BEGIN: begin
              cnt_d = '0; cur_d = '0;
              active_d  = eff_len != '0;
              latched_d = eff_len;
            end
            KIND_TEXT: begin
              if (hit_text) begin
                found_d = 1'b1;
                fcol_d  = col_plus[COL_W-1:0] - COL_W'(eff_len);
                cnt_d   = cnt_q + 1'b1;
              end
            end
            KIND_NEXT: begin
              if (cnt_q != '0) cur_d = (CNT_W'(cur_q) + 1'b1 >= cnt_q) ? '0 : cur_q + 1'b1;
            end
            KIND_PREV: begin
              if (cnt_q != '0)
                cur_d = (cur_q == '0 || CNT_W'(cur_q) >= cnt_q) ?
                        IDX_W'(cnt_q - 1'b1) : cur_q - 1'b1;
            end
            KIND_PROBE: begin
              if (active_q && cnt_q != '0) state_d = ST_SCAN_RD;
            end
            KIND_CLEAR: begin
              cnt_d = '0; cur_d = '0; active_d = 1'b0; latched_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (probe_hit) begin
          level_d = (scan_q == cur_q) ? LEVEL_CURRENT : LEVEL_MATCH;
          state_d = ST_CUR_RD;
        end else if (scan_next >= cnt_q) begin
          state_d = ST_CUR_RD;
        end else begin
          scan_d  = scan_next[IDX_W-1:0];
          state_d = ST_SCAN_RD;
        end
      end
      ST_CUR_RD: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[0]     = cnt_q == '0;
          out_data_d[1]     = found_q;
          out_data_d[17:2]  = found_q ? row_q : '0;
          out_data_d[29:18] = fcol_q;
          out_data_d[38:30] = TOTAL_W'(cnt_q);
          if (cnt_q != '0) begin
            out_data_d[46:39] = CIDX_W'(cur_q);
            out_data_d[62:47] = rd_row;
            out_data_d[74:63] = rd_col;
          end
          out_data_d[76:75] = level_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; cur_q <= '0; active_q <= 1'b0;
      latched_q <= '0; scan_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; cur_q <= cur_d; active_q <= active_d;
      latched_q <= latched_d; scan_q <= scan_d; out_valid_q <= out_valid_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    row_q <= row_d; col_q <= col_d; found_q <= found_d; fcol_q <= fcol_d;
    level_q <= level_d; out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // match count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_MAX)
    else $error("match count overflow");
  // a reported match always comes with a nonempty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("match reported with empty table");
  // current match stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> CNT_W'(cur_q) < cnt_q)
    else $error("current match out of range");
`endif

endmodule
